>>> design/csvt_pkg.sv
`default_nettype none

package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FIELD  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_FIELD  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_PLAIN  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // parser state carried from byte to byte
  typedef struct packed {
    mode_t mode;
    logic  prev_cr;
    logic  held_quote;
    logic  esc_pend;
    logic  held_cr;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode: MODE_RECORD, prev_cr: 1'b0, held_quote: 1'b0, esc_pend: 1'b0, held_cr: 1'b0
  };

endpackage

`default_nettype wire

>>> design/csvt_step.sv
`default_nettype none

// One parser step: current state and one input item give the next state
// and up to two results.
module csvt_step (
  input  var csvt_pkg::state_t         st,
  input  var csvt_pkg::in_t            din,
  output csvt_pkg::state_t             st_next,
  output csvt_pkg::out_t         [1:0] res,
  output logic                   [1:0] n
);
  import csvt_pkg::*;

  logic [7:0] b;
  logic       is_quote;
  logic       is_comma;
  logic       is_cr;
  logic       is_lf;
  logic       delim;
  logic       esc;

  function automatic out_t mk(input logic [1:0] kind, input logic [7:0] data);
    out_t r;
    r.kind     = kind;
    r.out_byte = (kind == KIND_DATA) ? data : 8'd0;
    r.last     = 1'b0;
    return r;
  endfunction

  assign b        = din.in_byte;
  assign is_quote = (b == CH_QUOTE);
  assign is_comma = (b == CH_COMMA);
  assign is_cr    = (b == CH_CR);
  assign is_lf    = (b == CH_LF);
  assign delim    = is_comma | is_cr | is_lf;

  always_comb begin
    st_next = st;
    res     = '0;
    n       = 2'd0;
    esc     = st.esc_pend;

    if (din.end_of_stream) begin
      if (st.mode == MODE_FIELD || st.mode == MODE_PLAIN) begin
        res[n[0]] = mk(KIND_RECORD, 8'd0);
        n = n + 2'd1;
      end else if (st.mode == MODE_QUOTED) begin
        if (st.held_cr) begin
          res[n[0]] = mk(KIND_DATA, CH_CR);
          n = n + 2'd1;
        end
        res[n[0]] = mk(KIND_RECORD, 8'd0);
        n = n + 2'd1;
      end
      st_next = STATE_RESET;
    end else begin
      unique case (st.mode)
        MODE_RECORD, MODE_FIELD: begin
          if (st.mode == MODE_RECORD && is_lf && st.prev_cr) begin
            // second half of CR LF, dropped
          end else if (delim) begin
            res[n[0]] = mk(is_comma ? KIND_FIELD : KIND_RECORD, 8'd0);
            n = n + 2'd1;
            st_next.mode = is_comma ? MODE_FIELD : MODE_RECORD;
          end else if (is_quote) begin
            st_next.mode = MODE_QUOTED;
          end else begin
            res[n[0]] = mk(KIND_DATA, b);
            n = n + 2'd1;
            st_next.mode = MODE_PLAIN;
          end
        end
        MODE_QUOTED: begin
          if (st.held_quote) begin
            if (delim) begin
              if (st.esc_pend) begin
                res[n[0]] = mk(KIND_DATA, CH_QUOTE);
                n = n + 2'd1;
              end
              st_next.held_quote = 1'b0;
              st_next.esc_pend   = 1'b0;
              st_next.held_cr    = 1'b0;
              res[n[0]] = mk(is_comma ? KIND_FIELD : KIND_RECORD, 8'd0);
              n = n + 2'd1;
              st_next.mode = is_comma ? MODE_FIELD : MODE_RECORD;
            end else begin
              if (st.esc_pend) begin
                res[n[0]] = mk(KIND_DATA, CH_QUOTE);
                n = n + 2'd1;
                esc = 1'b0;
              end else begin
                esc = 1'b1;
              end
              st_next.held_quote = is_quote;
              if (!is_quote) begin
                if (esc) begin
                  res[n[0]] = mk(KIND_DATA, CH_QUOTE);
                  n = n + 2'd1;
                  esc = 1'b0;
                end
                res[n[0]] = mk(KIND_DATA, b);
                n = n + 2'd1;
              end
              st_next.esc_pend = esc;
            end
          end else if (is_quote) begin
            if (st.held_cr) begin
              res[n[0]] = mk(KIND_DATA, CH_CR);
              n = n + 2'd1;
            end
            st_next.held_cr    = 1'b0;
            st_next.held_quote = 1'b1;
          end else if (is_cr) begin
            if (st.held_cr) begin
              res[n[0]] = mk(KIND_DATA, CH_CR);
              n = n + 2'd1;
            end
            st_next.held_cr = 1'b1;
          end else if (is_lf) begin
            // CR LF folds to LF
            res[n[0]] = mk(KIND_DATA, CH_LF);
            n = n + 2'd1;
            st_next.held_cr = 1'b0;
          end else begin
            if (st.held_cr) begin
              res[n[0]] = mk(KIND_DATA, CH_CR);
              n = n + 2'd1;
            end
            st_next.held_cr = 1'b0;
            res[n[0]] = mk(KIND_DATA, b);
            n = n + 2'd1;
          end
        end
        MODE_PLAIN: begin
          if (delim) begin
            res[n[0]] = mk(is_comma ? KIND_FIELD : KIND_RECORD, 8'd0);
            n = n + 2'd1;
            st_next.mode = is_comma ? MODE_FIELD : MODE_RECORD;
          end else begin
            res[n[0]] = mk(KIND_DATA, b);
            n = n + 2'd1;
          end
        end
        default: st_next = STATE_RESET;
      endcase
      st_next.prev_cr = is_cr;
    end

    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> design/csv_field_tokenizer_core.sv
`default_nettype none

// CSV field tokenizer.
// src channel: one raw CSV byte per transfer, or an end-of-stream marker.
// dst channel: field data bytes, end-of-field and end-of-record marks; the
// last flag closes the group of results caused by one src transfer (a src
// transfer may cause no result at all).
// Order: the first result of a group is on dst in the cycle after the src
// transfer that caused it; a second result follows once the first leaves dst.
// Throughput: one byte per cycle while dst does not stall. A byte that causes two
// results (a held quote or CR released together with the current byte) holds
// src stall while the two-entry output buffer drains.
// Stall: dst stall freezes the output buffer; src stall rises as soon as the
// buffer cannot take the next byte's results, and the parser state holds.
// Reset: rst (synchronous) returns the parser to record start and empties
// the output buffer. An end-of-stream transfer also returns the parser to
// record start after closing the open field and record.
module csv_field_tokenizer_core (
  input  var logic            clk,
  input  var logic            rst,
  input  var logic            src_valid,
  output logic                src_stall,
  input  var csvt_pkg::in_t   src_data,
  output logic                dst_valid,
  input  var logic            dst_stall,
  output csvt_pkg::out_t      dst_data
);
  import csvt_pkg::*;

  state_t           st;
  state_t           st_next;
  out_t       [1:0] res;
  logic       [1:0] n;

  // output buffer: buf0 is the head shown on dst
  out_t       buf0;
  out_t       buf1;
  logic [1:0] cnt;
  logic [1:0] cnt_next;

  logic src_xfer;
  logic dst_xfer;

  csvt_step u_step (
    .st      (st),
    .din     (src_data),
    .st_next (st_next),
    .res     (res),
    .n       (n)
  );

  assign dst_xfer  = dst_valid && !dst_stall;
  // take a byte when the buffer is empty or its single entry leaves now
  assign src_stall = !((cnt == 2'd0) || (cnt == 2'd1 && dst_xfer));
  assign src_xfer  = src_valid && !src_stall;
  assign dst_valid = (cnt != 2'd0);
  assign dst_data  = buf0;

  always_comb begin
    cnt_next = cnt;
    if (src_xfer) begin
      cnt_next = n;
    end else if (dst_xfer) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= STATE_RESET;
      cnt <= 2'd0;
    end else begin
      if (src_xfer) begin
        st <= st_next;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (src_xfer) begin
      buf0 <= res[0];
      buf1 <= res[1];
    end else if (dst_xfer) begin
      buf0 <= buf1;
    end
  end

`ifndef ASSERT_OFF
  // the first of a two-result group never carries last
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !buf0.last)
    else $error("first of two buffered results marked last");

  // held quote, pending escape and held CR exist only inside a quoted field
  a_hold_mode: assert property (@(posedge clk) disable iff (rst)
    (st.held_quote || st.esc_pend || st.held_cr) |-> (st.mode == MODE_QUOTED))
    else $error("held byte outside quoted field");

  a_hold_excl: assert property (@(posedge clk) disable iff (rst)
    !(st.held_quote && st.held_cr))
    else $error("quote and CR held together");

  // stream end returns the parser to record start
  a_eos_reset: assert property (@(posedge clk) disable iff (rst)
    (src_xfer && src_data.end_of_stream) |=> (st == STATE_RESET))
    else $error("parser not reset after stream end");
`endif

endmodule

`default_nettype wire
